// ===== rtl/leb_pkg.sv =====
// band table, action codes and row type for the earfcn band lookup
package leb_pkg;

    // rows in the constant band table
    localparam int ROM_ROWS      = 19;
    localparam int ROM_IDX_W     = $clog2(ROM_ROWS);
    localparam int NUM_BANDS_DEF = 19;
    // widest earfcn span of any row is 900 channels
    localparam int DIFF_W        = 10;
    localparam int KHZ_W         = 22;
    localparam int EARFCN_W      = 18;
    localparam int OFFSET_W      = 20;

    typedef enum logic [1:0] {
        ACT_EARFCN    = 2'd0,
        ACT_BAND      = 2'd1,
        ACT_DL_SEARCH = 2'd2,
        ACT_UL_SEARCH = 2'd3
    } t_action;

    // one band row; uplink edges are precomputed as downlink edge - offset
    typedef struct packed {
        logic [7:0]                 band;
        logic [KHZ_W-1:0]           dl_lo;
        logic [KHZ_W-1:0]           dl_hi;
        logic [KHZ_W-1:0]           ul_lo;
        logic [KHZ_W-1:0]           ul_hi;
        logic [EARFCN_W-1:0]        e_lo;
        logic [EARFCN_W-1:0]        e_hi;
        logic signed [OFFSET_W-1:0] offset;
    } t_band_row;

    function automatic t_band_row mk_row(
        input logic [7:0]                 band,
        input logic [KHZ_W-1:0]           dl_lo,
        input logic [KHZ_W-1:0]           dl_hi,
        input logic [KHZ_W-1:0]           ul_lo,
        input logic [KHZ_W-1:0]           ul_hi,
        input logic [EARFCN_W-1:0]        e_lo,
        input logic [EARFCN_W-1:0]        e_hi,
        input logic signed [OFFSET_W-1:0] offset
    );
        t_band_row r;
        r.band   = band;
        r.dl_lo  = dl_lo;
        r.dl_hi  = dl_hi;
        r.ul_lo  = ul_lo;
        r.ul_hi  = ul_hi;
        r.e_lo   = e_lo;
        r.e_hi   = e_hi;
        r.offset = offset;
        return r;
    endfunction

    // constant band rom, downlink-only rows carry zero uplink edges
    function automatic t_band_row band_rom(input logic [ROM_IDX_W-1:0] idx);
        t_band_row r;
        case (idx)
            5'd0:  r = mk_row(8'd1,  22'd2110000, 22'd2170000, 22'd1920000, 22'd1980000,
                              18'd0,     18'd599,   20'sd190000);
            5'd1:  r = mk_row(8'd2,  22'd1930000, 22'd1990000, 22'd1850000, 22'd1910000,
                              18'd600,   18'd1199,  20'sd80000);
            5'd2:  r = mk_row(8'd3,  22'd1805000, 22'd1880000, 22'd1710000, 22'd1785000,
                              18'd1200,  18'd1949,  20'sd95000);
            5'd3:  r = mk_row(8'd4,  22'd2110000, 22'd2155000, 22'd1710000, 22'd1755000,
                              18'd1950,  18'd2399,  20'sd400000);
            5'd4:  r = mk_row(8'd5,  22'd869000,  22'd894000,  22'd824000,  22'd849000,
                              18'd2400,  18'd2649,  20'sd45000);
            5'd5:  r = mk_row(8'd7,  22'd2620000, 22'd2690000, 22'd2500000, 22'd2570000,
                              18'd2750,  18'd3449,  20'sd120000);
            5'd6:  r = mk_row(8'd8,  22'd925000,  22'd960000,  22'd890000,  22'd925000,
                              18'd3450,  18'd3799,  20'sd35000);
            5'd7:  r = mk_row(8'd12, 22'd729000,  22'd746000,  22'd699000,  22'd716000,
                              18'd5010,  18'd5179,  20'sd30000);
            5'd8:  r = mk_row(8'd13, 22'd746000,  22'd756000,  22'd777000,  22'd787000,
                              18'd5180,  18'd5279,  -20'sd31000);
            5'd9:  r = mk_row(8'd14, 22'd758000,  22'd768000,  22'd788000,  22'd798000,
                              18'd5280,  18'd5379,  -20'sd30000);
            5'd10: r = mk_row(8'd17, 22'd734000,  22'd746000,  22'd704000,  22'd716000,
                              18'd5730,  18'd5849,  20'sd30000);
            5'd11: r = mk_row(8'd20, 22'd791000,  22'd821000,  22'd832000,  22'd862000,
                              18'd6150,  18'd6449,  -20'sd41000);
            5'd12: r = mk_row(8'd25, 22'd1930000, 22'd1995000, 22'd1850000, 22'd1915000,
                              18'd8040,  18'd8689,  20'sd80000);
            5'd13: r = mk_row(8'd26, 22'd859000,  22'd894000,  22'd814000,  22'd849000,
                              18'd8690,  18'd9039,  20'sd45000);
            5'd14: r = mk_row(8'd28, 22'd758000,  22'd803000,  22'd703000,  22'd748000,
                              18'd9210,  18'd9659,  20'sd55000);
            5'd15: r = mk_row(8'd29, 22'd717000,  22'd728000,  22'd0,       22'd0,
                              18'd9660,  18'd9769,  20'sd0);
            5'd16: r = mk_row(8'd30, 22'd2350000, 22'd2360000, 22'd2305000, 22'd2315000,
                              18'd9770,  18'd9869,  20'sd45000);
            5'd17: r = mk_row(8'd66, 22'd2110000, 22'd2200000, 22'd1710000, 22'd1800000,
                              18'd66436, 18'd67335, 20'sd400000);
            5'd18: r = mk_row(8'd71, 22'd617000,  22'd652000,  22'd663000,  22'd698000,
                              18'd68586, 18'd68935, -20'sd46000);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/lte_earfcn_band_lookup.sv =====
// earfcn to band and frequency lookup, iterative scan over the band rom
// Timing: a command is taken when start is high and busy is low, and busy
// stays high until its last result beat. The sequencer walks the band rom one
// row per cycle through a single shared 22-bit adder. An earfcn lookup
// (actions 0 and 1) scans rows up to the matching row, then takes three
// adder passes to form dl = low edge + 100 * channel offset and one more for
// ul = dl - duplex offset. A frequency search (actions 2 and 3) always scans
// all rows and emits its final beat from a flush state after the last row.
// Results come out on o_strobe for exactly one cycle each; the receiver cannot
// stall, and the final beat of a command carries o_last.
// A search holds back each match by one so that o_last lands on the final one.
module lte_earfcn_band_lookup
    import leb_pkg::*;
#(
    parameter int NUM_BANDS = NUM_BANDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    input  logic [7:0]          i_band_number,
    input  logic [EARFCN_W-1:0] i_earfcn,
    input  logic [KHZ_W-1:0]    i_freq_khz,
    output logic                o_strobe,
    output logic                o_found,
    output logic [7:0]          o_matched_band,
    output logic [EARFCN_W-1:0] o_earfcn_low,
    output logic [EARFCN_W-1:0] o_earfcn_high,
    output logic [KHZ_W-1:0]    o_dl_khz,
    output logic [KHZ_W-1:0]    o_ul_khz,
    output logic                o_has_uplink,
    output logic                o_last
);

    localparam int ROWS_USED = (NUM_BANDS < ROM_ROWS) ? NUM_BANDS : ROM_ROWS;
    localparam int IDX_W     = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_UL,
        S_FLUSH
    } t_state;

    // control
    t_state            r_state,    n_state;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic              r_pend_vld, n_pend_vld;
    logic              r_strobe,   n_strobe;
    // command and work registers
    t_action           r_action,   n_action;
    logic [7:0]        r_band,     n_band;
    logic [EARFCN_W-1:0] r_earfcn, n_earfcn;
    logic [KHZ_W-1:0]  r_freq,     n_freq;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;
    logic [DIFF_W-1:0] r_diff,     n_diff;
    logic [KHZ_W-1:0]  r_acc,      n_acc;
    // result registers
    logic              r_found,    n_found;
    logic [7:0]        r_mband,    n_mband;
    logic [EARFCN_W-1:0] r_elo,    n_elo;
    logic [EARFCN_W-1:0] r_ehi,    n_ehi;
    logic [KHZ_W-1:0]  r_dl,       n_dl;
    logic [KHZ_W-1:0]  r_ul,       n_ul;
    logic              r_hasul,    n_hasul;
    logic              r_last,     n_last;

    t_band_row         row_s;
    t_band_row         row_p;
    logic              up_s;
    logic              up_p;
    logic              last_row;
    logic              band_ok;
    logic              in_rng;
    logic              hit_srch;

    // shared adder
    logic [KHZ_W-1:0]  add_a;
    logic [KHZ_W-1:0]  add_b;
    logic              add_cin;
    logic [KHZ_W-1:0]  add_sum;

    // rom reads: row under scan and held match row
    assign row_s    = band_rom(ROM_IDX_W'(r_idx));
    assign row_p    = band_rom(ROM_IDX_W'(r_pend_idx));
    assign up_s     = (row_s.offset != '0);
    assign up_p     = (row_p.offset != '0);
    assign last_row = (r_idx == IDX_W'(ROWS_USED - 1));

    // row compares
    assign band_ok  = (r_action != ACT_BAND) || (row_s.band == r_band);
    assign in_rng   = (r_earfcn >= row_s.e_lo) && (r_earfcn <= row_s.e_hi);
    assign hit_srch = (r_action == ACT_DL_SEARCH) ?
                      ((r_freq >= row_s.dl_lo) && (r_freq < row_s.dl_hi)) :
                      (up_s && (r_freq >= row_s.ul_lo) && (r_freq < row_s.ul_hi));

    // adder operand select per sequencer step
    always_comb begin
        add_a   = r_acc;
        add_b   = '0;
        add_cin = 1'b0;
        case (r_state)
            S_SCAN: begin
                add_a   = KHZ_W'(r_earfcn);
                add_b   = ~KHZ_W'(row_s.e_lo);
                add_cin = 1'b1;
            end
            S_MUL1: begin
                add_a = row_p.dl_lo;
                add_b = KHZ_W'({r_diff, 6'b0});
            end
            S_MUL2: begin
                add_b = KHZ_W'({r_diff, 5'b0});
            end
            S_MUL3: begin
                add_b = KHZ_W'({r_diff, 2'b0});
            end
            S_UL: begin
                add_b   = ~KHZ_W'(row_p.offset);
                add_cin = 1'b1;
            end
            default: begin
                add_a = r_acc;
            end
        endcase
    end

    assign add_sum = add_a + add_b + KHZ_W'(add_cin);

    // sequencer next state and result beats
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        n_action   = r_action;
        n_band     = r_band;
        n_earfcn   = r_earfcn;
        n_freq     = r_freq;
        n_diff     = r_diff;
        n_acc      = r_acc;
        n_strobe   = 1'b0;
        n_found    = r_found;
        n_mband    = r_mband;
        n_elo      = r_elo;
        n_ehi      = r_ehi;
        n_dl       = r_dl;
        n_ul       = r_ul;
        n_hasul    = r_hasul;
        n_last     = r_last;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action   = t_action'(i_action);
                    n_band     = i_band_number;
                    n_earfcn   = i_earfcn;
                    n_freq     = i_freq_khz;
                    n_idx      = '0;
                    n_pend_vld = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_action == ACT_EARFCN || r_action == ACT_BAND) begin
                    if (band_ok && in_rng) begin
                        n_pend_idx = r_idx;
                        n_diff     = add_sum[DIFF_W-1:0];
                        n_state    = S_MUL1;
                    end else if ((r_action == ACT_BAND && band_ok) || last_row) begin
                        // no match beat
                        n_strobe = 1'b1;
                        n_found  = 1'b0;
                        n_mband  = '0;
                        n_elo    = '0;
                        n_ehi    = '0;
                        n_dl     = '0;
                        n_ul     = '0;
                        n_hasul  = 1'b0;
                        n_last   = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    if (hit_srch) begin
                        // release the held match, hold this one
                        if (r_pend_vld) begin
                            n_strobe = 1'b1;
                            n_found  = 1'b1;
                            n_mband  = row_p.band;
                            n_elo    = row_p.e_lo;
                            n_ehi    = row_p.e_hi;
                            n_dl     = row_p.dl_lo;
                            n_ul     = up_p ? row_p.ul_lo : '0;
                            n_hasul  = up_p;
                            n_last   = 1'b0;
                        end
                        n_pend_idx = r_idx;
                        n_pend_vld = 1'b1;
                    end
                    if (last_row) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_MUL1: begin
                n_acc   = add_sum;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_acc   = add_sum;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                n_acc   = add_sum;
                n_state = S_UL;
            end
            S_UL: begin
                n_strobe = 1'b1;
                n_found  = 1'b1;
                n_mband  = row_p.band;
                n_elo    = row_p.e_lo;
                n_ehi    = row_p.e_hi;
                n_dl     = r_acc;
                n_ul     = up_p ? add_sum : '0;
                n_hasul  = up_p;
                n_last   = 1'b1;
                n_state  = S_IDLE;
            end
            S_FLUSH: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                if (r_pend_vld) begin
                    n_found = 1'b1;
                    n_mband = row_p.band;
                    n_elo   = row_p.e_lo;
                    n_ehi   = row_p.e_hi;
                    n_dl    = row_p.dl_lo;
                    n_ul    = up_p ? row_p.ul_lo : '0;
                    n_hasul = up_p;
                end else begin
                    n_found = 1'b0;
                    n_mband = '0;
                    n_elo   = '0;
                    n_ehi   = '0;
                    n_dl    = '0;
                    n_ul    = '0;
                    n_hasul = 1'b0;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, work and result registers
    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_band     <= n_band;
        r_earfcn   <= n_earfcn;
        r_freq     <= n_freq;
        r_pend_idx <= n_pend_idx;
        r_diff     <= n_diff;
        r_acc      <= n_acc;
        r_idx      <= n_idx;
        r_found    <= n_found;
        r_mband    <= n_mband;
        r_elo      <= n_elo;
        r_ehi      <= n_ehi;
        r_dl       <= n_dl;
        r_ul       <= n_ul;
        r_hasul    <= n_hasul;
        r_last     <= n_last;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pend_vld <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_strobe   <= n_strobe;
        end
    end

    // outputs
    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_found        = r_found;
    assign o_matched_band = r_mband;
    assign o_earfcn_low   = r_elo;
    assign o_earfcn_high  = r_ehi;
    assign o_dl_khz       = r_dl;
    assign o_ul_khz       = r_ul;
    assign o_has_uplink   = r_hasul;
    assign o_last         = r_last;

endmodule

// ===== rtl/leb_checker.sv =====
// port-level checker for the earfcn band lookup, bound to the top level
module leb_checker
    import leb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_strobe,
    input logic                o_found,
    input logic [KHZ_W-1:0]    o_ul_khz,
    input logic                o_has_uplink,
    input logic                o_last
);

    // an accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted command");

    // every result beat comes out of a running command
    a_beat_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a running command");

    // a no-match beat is always the only and final one
    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_found |-> o_last)
        else $error("no-match beat not marked last");

    // downlink-only bands report no uplink frequency
    a_no_ul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_has_uplink |-> o_ul_khz == '0)
        else $error("uplink frequency on a downlink-only band");

    // the final beat is never followed directly by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("beat right after final beat");

endmodule

bind lte_earfcn_band_lookup leb_checker u_leb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_found      (o_found),
    .o_ul_khz     (o_ul_khz),
    .o_has_uplink (o_has_uplink),
    .o_last       (o_last)
);
